>>> src/wsd_pkg.sv
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_LEN  = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_CONT  = 3'd1;
   localparam logic [2:0] ERR_PING  = 3'd2;
   localparam logic [2:0] ERR_PONG  = 3'd3;
   localparam logic [2:0] ERR_BADOP = 3'd4;
   localparam logic [2:0] ERR_LARGE = 3'd5;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16328;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       last_of_frame;
      logic [3:0] frame_opcode;
      logic       fin_flag;
      logic [2:0] error_code;
   } rsp_item_type;

   typedef struct packed {
      logic      halted;
      phase_type phase;
   } front_stat_type;

endpackage

>>> src/websocket_frame_deframer_unit.sv
// websocket receive deframer for client-to-server frames
// req_ channel: one received byte per transfer on req_tdata. the parser
//   reads the header (fin, opcode, 7/16/64-bit length, 4-byte mask) and
//   unmasks the payload; every byte is taken, one per cycle while the queue has room.
// rsp_ channel: one result per payload byte, one marker for an empty frame,
//   one close event or one error. tuser carries the kind, tlast the end of
//   a frame's payload. after close or any error, bytes are taken and dropped.
// csr_: csr_wen loads csr_wdata as the largest accepted payload length.
// path: a result is written into the queue by the front parse, then moved from
//   the queue into the output register.
// throughput: one byte per cycle while req_tready is high; header bytes give
//   no result but for a close, an error or an empty-frame marker.
// reset: parser returns to the first header byte, the halt is cleared,
//   the queue and output register are emptied, the limit goes to 16328.
// stall: when rsp_tready is low the output register holds, the queue fills
//   (QUEUE_DEPTH entries) and req_tready drops until space returns.
module websocket_frame_deframer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [11:8] frame_opcode, [12] fin_flag, [15:13] error_code
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last_of_frame
   input  logic        csr_wen,
   input  logic [31:0] csr_wdata
);

   logic                    accept;
   logic                    push;
   logic                    q_full;
   logic                    q_valid;
   logic                    pop;
   wsd_pkg::rsp_item_type   push_item;
   wsd_pkg::rsp_item_type   head_item;
   wsd_pkg::front_stat_type front_stat;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   wsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_tdata),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .push      (push),
      .item      (push_item),
      .stat      (front_stat)
   );

   wsd_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   wsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // once halted the parser must never produce another result
   a_halt_silent : assert property (@(posedge clock) disable iff (reset)
      front_stat.halted |-> !push)
      else $error("result produced after close or error");

   // error code is set exactly on error results
   a_err_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == wsd_pkg::KIND_ERROR) ==
                      (rsp_tdata[15:13] != wsd_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   // only payload results carry a data byte
   a_data_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != wsd_pkg::KIND_DATA) |-> rsp_tdata[7:0] == 8'd0)
      else $error("non-payload result carries data");

   // a result enters the queue only in the cycle its byte is taken
   a_push_on_accept : assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("result produced without an input transfer");

endmodule

>>> src/wsd_front.sv
module wsd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   input  logic                   csr_wen,
   input  logic [31:0]            csr_wdata,
   output logic                   push,
   output wsd_pkg::rsp_item_type  item,
   output wsd_pkg::front_stat_type stat
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] remain_ff, remain_in;
   logic [3:0]  op_ff, op_in;
   logic        fin_ff, fin_in;
   logic [31:0] max_ff;

   logic [3:0]  op;
   logic        fin;
   logic [6:0]  len7;
   logic [63:0] ext_len;
   logic [31:0] next_key;
   logic [3:0]  cnt_dec;
   logic        too7;
   logic        too_ext;
   logic        last;
   logic [7:0]  key_byte;
   logic        work;

   assign work     = accept && !halted_ff;
   assign op       = rx_byte[3:0];
   assign fin      = rx_byte[7];
   assign len7     = rx_byte[6:0];
   assign ext_len  = {len_ff[55:0], rx_byte};
   assign next_key = {key_ff[23:0], rx_byte};
   assign cnt_dec  = cnt_ff - 4'd1;
   assign too7     = {25'd0, len7} > max_ff;
   assign too_ext  = (|ext_len[63:32]) || (ext_len[31:0] > max_ff);
   assign last     = remain_ff == 32'd1;

   always_comb begin
      case (idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (work) begin
         case (phase_ff)
            wsd_pkg::PH_LEN: begin
               if (len7 == wsd_pkg::LEN_EXT16 || len7 == wsd_pkg::LEN_EXT64) begin
                  phase_in = wsd_pkg::PH_EXT;
               end else if (!too7) begin
                  phase_in = wsd_pkg::PH_KEY;
               end
            end
            wsd_pkg::PH_EXT: begin
               if (cnt_dec == 4'd0 && !too_ext) begin
                  phase_in = wsd_pkg::PH_KEY;
               end
            end
            wsd_pkg::PH_KEY: begin
               if (cnt_dec == 4'd0) begin
                  phase_in = (len_ff == 64'd0) ? wsd_pkg::PH_HDR : wsd_pkg::PH_DATA;
               end
            end
            wsd_pkg::PH_DATA: begin
               if (last) begin
                  phase_in = wsd_pkg::PH_HDR;
               end
            end
            default: begin
               if (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BINARY) begin
                  phase_in = wsd_pkg::PH_LEN;
               end
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      halted_in = halted_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      remain_in = remain_ff;
      op_in     = op_ff;
      fin_in    = fin_ff;
      push      = 1'b0;
      item.kind          = wsd_pkg::KIND_DATA;
      item.payload_byte  = 8'd0;
      item.last_of_frame = 1'b0;
      item.frame_opcode  = op_ff;
      item.fin_flag      = fin_ff;
      item.error_code    = wsd_pkg::ERR_NONE;
      if (work) begin
         case (phase_ff)
            wsd_pkg::PH_LEN: begin
               if (len7 == wsd_pkg::LEN_EXT16) begin
                  len_in = 64'd0;
                  cnt_in = 4'd2;
               end else if (len7 == wsd_pkg::LEN_EXT64) begin
                  len_in = 64'd0;
                  cnt_in = 4'd8;
               end else begin
                  len_in = {57'd0, len7};
                  if (too7) begin
                     halted_in       = 1'b1;
                     push            = 1'b1;
                     item.kind       = wsd_pkg::KIND_ERROR;
                     item.error_code = wsd_pkg::ERR_LARGE;
                  end else begin
                     cnt_in = 4'd4;
                  end
               end
            end
            wsd_pkg::PH_EXT: begin
               len_in = ext_len;
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0) begin
                  if (too_ext) begin
                     halted_in       = 1'b1;
                     push            = 1'b1;
                     item.kind       = wsd_pkg::KIND_ERROR;
                     item.error_code = wsd_pkg::ERR_LARGE;
                  end else begin
                     cnt_in = 4'd4;
                  end
               end
            end
            wsd_pkg::PH_KEY: begin
               key_in = next_key;
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0) begin
                  idx_in    = 2'd0;
                  remain_in = len_ff[31:0];
                  if (len_ff == 64'd0) begin
                     push               = 1'b1;
                     item.kind          = wsd_pkg::KIND_EMPTY;
                     item.last_of_frame = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_DATA: begin
               push               = 1'b1;
               item.payload_byte  = rx_byte ^ key_byte;
               item.last_of_frame = last;
               remain_in          = remain_ff - 32'd1;
               idx_in             = last ? 2'd0 : idx_ff + 2'd1;
            end
            default: begin
               item.frame_opcode = op;
               item.fin_flag     = fin;
               case (op)
                  wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY: begin
                     op_in  = op;
                     fin_in = fin;
                  end
                  wsd_pkg::OP_CLOSE: begin
                     halted_in = 1'b1;
                     push      = 1'b1;
                     item.kind = wsd_pkg::KIND_CLOSE;
                  end
                  default: begin
                     halted_in = 1'b1;
                     push      = 1'b1;
                     item.kind = wsd_pkg::KIND_ERROR;
                     case (op)
                        wsd_pkg::OP_CONT: item.error_code = wsd_pkg::ERR_CONT;
                        wsd_pkg::OP_PING: item.error_code = wsd_pkg::ERR_PING;
                        wsd_pkg::OP_PONG: item.error_code = wsd_pkg::ERR_PONG;
                        default:          item.error_code = wsd_pkg::ERR_BADOP;
                     endcase
                  end
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wsd_pkg::PH_HDR;
         halted_ff <= 1'b0;
         cnt_ff    <= 4'd0;
         idx_ff    <= 2'd0;
         max_ff    <= wsd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         if (csr_wen) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      key_ff    <= key_in;
      remain_ff <= remain_in;
      op_ff     <= op_in;
      fin_ff    <= fin_in;
   end

   assign stat.halted = halted_ff;
   assign stat.phase  = phase_ff;

endmodule

>>> src/wsd_queue.sv
module wsd_queue #(
   parameter int Depth = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wsd_pkg::rsp_item_type push_item,
   input  logic                  pop,
   output logic                  full,
   output logic                  head_valid,
   output wsd_pkg::rsp_item_type head_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   wsd_pkg::rsp_item_type mem [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full       = cnt_ff == FullCnt;
   assign head_valid = cnt_ff != '0;
   assign head_item  = mem[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/wsd_back.sv
module wsd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  wsd_pkg::rsp_item_type head_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic                  valid_ff, valid_in;
   wsd_pkg::rsp_item_type out_ff;

   // refill the output register when it is empty or being taken
   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_of_frame;
   assign rsp_tdata  = {out_ff.error_code, out_ff.fin_flag, out_ff.frame_opcode,
                        out_ff.payload_byte};

endmodule
